// ===== rtl/fcm_pkg.sv =====
// Shared types and constants of the FIR convolution core.
// Used by the tap cell, the result queue and the top level; no dependencies.
`default_nettype none

package fcm_pkg;

   // Default parameter values of the top level.
   localparam int MAX_TAPS_DEF    = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed field widths.
   localparam int COEF_BITS       = 16;
   localparam int FILTERED_BITS   = 36;
   localparam int RSP_DATA_BITS   = ((FILTERED_BITS + 7) / 8) * 8;
   localparam int TAP_COUNT_BITS  = 5;
   localparam int MODE_BITS       = 2;

   // Coefficient banks: four taps of 16 bits in each 64-bit register.
   localparam int NUM_BANKS       = 4;
   localparam int TAPS_PER_BANK   = 4;
   localparam int BANK_BITS       = COEF_BITS * TAPS_PER_BANK;
   localparam int REG_TAPS        = NUM_BANKS * TAPS_PER_BANK;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONV_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_COUNT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B1   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B2   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B3   = 3'd5;

   // Output range codes.
   localparam logic [MODE_BITS-1:0] MODE_FULL  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SAME  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_VALID = 2'd2;

   // One result word as it waits in the output queue.
   typedef struct packed {
      logic                            empty;
      logic                            last;
      logic signed [FILTERED_BITS-1:0] filtered;
   } out_word_type;

endpackage

`default_nettype wire

// ===== rtl/fcm_tap_cell.sv =====
// One cell of the transposed FIR chain: a multiplier, an adder and one partial sum register.
// Depends on fcm_pkg for the coefficient and sum widths.
`default_nettype none

module fcm_tap_cell
   import fcm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               step,
   input  wire                               clear,
   input  wire  signed [SAMPLE_BITS-1:0]     x,
   input  wire  signed [COEF_BITS-1:0]       coef,
   input  wire  signed [FILTERED_BITS-1:0]   sum_in,
   output logic signed [FILTERED_BITS-1:0]   psum
);

   logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod;
   logic signed [FILTERED_BITS-1:0]         part_ff;

   // Sums wrap modulo the result width, so the product is sign extended or cut to it.
   assign prod = x * coef;
   assign psum = FILTERED_BITS'(prod) + part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
      end else if (step) begin
         if (clear) begin
            part_ff <= '0;
         end else begin
            part_ff <= sum_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fcm_out_queue.sv =====
// Two-word result queue that decouples the tap chain from the result channel.
// Depends on fcm_pkg for the result word type.
`default_nettype none

module fcm_out_queue
   import fcm_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   input  out_word_type push_word,
   output logic         can_push,
   output logic         pop_valid,
   input  wire          pop_ready,
   output out_word_type pop_word
);

   out_word_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         pop;

   assign can_push  = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_word  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fir_convolution_modes_core.sv =====
// Top level of the streaming FIR convolution core with full, same and valid output ranges.
// Depends on fcm_pkg, fcm_tap_cell and fcm_out_queue.
`default_nettype none

// This core convolves each frame of signed samples with a kernel of 1 to 16 signed 16-bit taps
// and returns every output at full precision (36 bits, wrapping, no saturation). conv_mode
// picks full, same (centered) or valid output; mode 3 gives no outputs. The filter is a
// transposed chain of MAX_TAPS identical cells: each incoming sample is broadcast to all cells,
// and every cell adds its product to the partial sum handed over by its right neighbor, so one
// sample word is taken per clock while streaming with room in the result queue; its result, if
// any, is pushed into that queue in the same step. After the word marked with req_tlast, the
// core runs the tail flush on its own, feeding M-1 zeros into the chain in full mode and
// (M-1)/2 zeros in same mode (M is the tap count in use); req_tready stays low during the flush.
// Results pass through a two-word queue, so the core keeps taking samples while a result waits
// on the result channel. The frame's final result carries rsp_tlast; a frame that produces no
// output returns a single word with rsp_tuser set, zero data and rsp_tlast low. The chain
// clears itself at the end of each frame. Configuration must be written while no frame is in
// progress.

module fir_convolution_modes_core
   import fcm_pkg::*;
#(
   parameter int MAX_TAPS    = MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Sample channel.
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,   // sample, zero padding above
   input  wire                                   req_tlast,   // frame_end
   // Result channel.
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [RSP_DATA_BITS-1:0]              rsp_tdata,   // filtered, zero padding above
   output logic                                  rsp_tlast,   // last_output
   output logic                                  rsp_tuser,   // empty_frame
   // Configuration write port.
   input  wire                                   csr_wr_en,
   input  wire  [CSR_INDEX_BITS-1:0]             csr_index,
   input  wire  [BANK_BITS-1:0]                  csr_wdata
);

   localparam int SEEN_W = $clog2(MAX_TAPS + 1);
   localparam int IDX_W  = $clog2(MAX_TAPS + 32);

   typedef enum logic {
      ST_STREAM,
      ST_FLUSH
   } state_type;

   // Configuration registers.
   logic [MODE_BITS-1:0]      conv_mode_ff;
   logic [TAP_COUNT_BITS-1:0] tap_count_ff;
   logic [BANK_BITS-1:0]      coef_bank_ff [NUM_BANKS];

   // Frame control.
   state_type                 state_ff, state_in;
   logic [SEEN_W-1:0]         seen_ff, seen_in;
   logic [TAP_COUNT_BITS-1:0] flush_left_ff, flush_left_in;
   logic [IDX_W-1:0]          flush_idx_ff, flush_idx_in;

   // Derived settings.
   logic [TAP_COUNT_BITS-1:0] taps_used;
   logic [TAP_COUNT_BITS-1:0] skip_count;
   logic [TAP_COUNT_BITS-1:0] flush_len;
   logic                      active;

   // Chain and queue signals.
   logic signed [SAMPLE_BITS-1:0]   chain_x;
   logic signed [COEF_BITS-1:0]     coef_eff [MAX_TAPS];
   logic signed [FILTERED_BITS-1:0] psum     [MAX_TAPS];
   logic                            chain_step;
   logic                            chain_clear;
   logic                            q_can_push;
   logic                            q_push;
   out_word_type                    q_push_word;
   out_word_type                    q_pop_word;
   logic                            in_accept;
   logic                            flush_step;
   logic [SEEN_W-1:0]               seen_next;
   logic                            emit_now;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         conv_mode_ff <= MODE_FULL;
         tap_count_ff <= TAP_COUNT_BITS'(1);
         for (int b = 0; b < NUM_BANKS; b++) begin
            coef_bank_ff[b] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CONV_MODE: conv_mode_ff    <= csr_wdata[MODE_BITS-1:0];
            CSR_TAP_COUNT: tap_count_ff    <= csr_wdata[TAP_COUNT_BITS-1:0];
            CSR_COEF_B0:   coef_bank_ff[0] <= csr_wdata;
            CSR_COEF_B1:   coef_bank_ff[1] <= csr_wdata;
            CSR_COEF_B2:   coef_bank_ff[2] <= csr_wdata;
            CSR_COEF_B3:   coef_bank_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A tap count of zero acts as one tap, and counts above MAX_TAPS saturate.
   always_comb begin
      if (tap_count_ff == '0) begin
         taps_used = TAP_COUNT_BITS'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         taps_used = TAP_COUNT_BITS'(MAX_TAPS);
      end else begin
         taps_used = tap_count_ff;
      end

      active = 1'b1;
      case (conv_mode_ff)
         MODE_FULL: begin
            skip_count = '0;
            flush_len  = taps_used - TAP_COUNT_BITS'(1);
         end
         MODE_SAME: begin
            skip_count = (taps_used - TAP_COUNT_BITS'(1)) >> 1;
            flush_len  = skip_count;
         end
         MODE_VALID: begin
            skip_count = taps_used - TAP_COUNT_BITS'(1);
            flush_len  = '0;
         end
         default: begin
            // The spare mode code produces no outputs at all.
            skip_count = '0;
            flush_len  = '0;
            active     = 1'b0;
         end
      endcase
   end

   // Effective taps: taps beyond the count in use, or without a register, are zero.
   for (genvar j = 0; j < MAX_TAPS; j++) begin : g_coef
      if (j < REG_TAPS) begin : g_reg
         assign coef_eff[j] = (int'(taps_used) > j)
            ? $signed(coef_bank_ff[j / TAPS_PER_BANK]
                      [COEF_BITS * (j % TAPS_PER_BANK) +: COEF_BITS])
            : '0;
      end else begin : g_zero
         assign coef_eff[j] = '0;
      end
   end

   // The tap chain. Cell 0 yields the output of the current step.
   assign chain_x = (state_ff == ST_FLUSH) ? '0 : $signed(req_tdata[SAMPLE_BITS-1:0]);

   for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
      logic signed [FILTERED_BITS-1:0] sum_from_right;

      if (j == MAX_TAPS - 1) begin : g_end
         assign sum_from_right = '0;
      end else begin : g_mid
         assign sum_from_right = psum[j + 1];
      end

      fcm_tap_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .step   (chain_step),
         .clear  (chain_clear),
         .x      (chain_x),
         .coef   (coef_eff[j]),
         .sum_in (sum_from_right),
         .psum   (psum[j])
      );
   end

   // Step control. Each step of the chain pushes at most one result word.
   always_comb begin
      req_tready = (state_ff == ST_STREAM) && q_can_push;
      in_accept  = req_tvalid && req_tready;
      flush_step = (state_ff == ST_FLUSH) && q_can_push;
      chain_step = in_accept || flush_step;

      seen_next = (int'(seen_ff) < MAX_TAPS) ? seen_ff + SEEN_W'(1) : seen_ff;
      // Output index seen_next-1 is kept once it reaches the leading skip.
      emit_now  = active && (int'(seen_next) > int'(skip_count));

      state_in      = state_ff;
      seen_in       = seen_ff;
      flush_left_in = flush_left_ff;
      flush_idx_in  = flush_idx_ff;
      chain_clear   = 1'b0;
      q_push        = 1'b0;
      q_push_word.filtered = psum[0];
      q_push_word.last     = 1'b0;
      q_push_word.empty    = 1'b0;

      if (in_accept) begin
         seen_in = seen_next;
         if (req_tlast) begin
            seen_in = '0;
            if (flush_len == '0) begin
               // No tail: this step closes the frame.
               chain_clear = 1'b1;
               q_push      = 1'b1;
               if (emit_now) begin
                  q_push_word.last = 1'b1;
               end else begin
                  q_push_word.empty    = 1'b1;
                  q_push_word.filtered = '0;
               end
            end else begin
               q_push        = emit_now;
               state_in      = ST_FLUSH;
               flush_left_in = flush_len;
               flush_idx_in  = IDX_W'(seen_next);
            end
         end else begin
            q_push = emit_now;
         end
      end

      if (flush_step) begin
         flush_idx_in  = flush_idx_ff + IDX_W'(1);
         flush_left_in = flush_left_ff - TAP_COUNT_BITS'(1);
         if (flush_left_ff == TAP_COUNT_BITS'(1)) begin
            // Final flush step: the tail outputs form a contiguous run at the end, so if
            // this one is skipped the whole frame had no output.
            chain_clear = 1'b1;
            state_in    = ST_STREAM;
            q_push      = 1'b1;
            if (int'(flush_idx_ff) >= int'(skip_count)) begin
               q_push_word.last = 1'b1;
            end else begin
               q_push_word.empty    = 1'b1;
               q_push_word.filtered = '0;
            end
         end else begin
            q_push = (int'(flush_idx_ff) >= int'(skip_count));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_STREAM;
         seen_ff       <= '0;
         flush_left_ff <= '0;
         flush_idx_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         seen_ff       <= seen_in;
         flush_left_ff <= flush_left_in;
         flush_idx_ff  <= flush_idx_in;
      end
   end

   fcm_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_push_word),
      .can_push  (q_can_push),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_word  (q_pop_word)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - FILTERED_BITS){1'b0}}, q_pop_word.filtered};
   assign rsp_tlast = q_pop_word.last;
   assign rsp_tuser = q_pop_word.empty;

endmodule

`default_nettype wire
